FILE: rtl/lmbc_pkg.sv
// Shared types, constants and mode codes for the LED mode and blink controller.
`default_nettype none
package lmbc_pkg;

  localparam int LMBC_TIME_WIDTH = 32;
  localparam int NOW_W           = 32;
  localparam int DUR_W           = 16;
  localparam int CFG_IDX_W       = 8;
  localparam int IN_TDATA_W      = 40;
  localparam int OUT_TDATA_W     = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_HALF = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PHASE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PHASE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BICOLOR_HALF   = 8'd3;

  // Configuration reset values
  localparam logic [DUR_W-1:0] HEARTBEAT_HALF_RST = 16'd500;
  localparam logic [DUR_W-1:0] SHORT_PHASE_RST    = 16'd200;
  localparam logic [DUR_W-1:0] LONG_PHASE_RST     = 16'd800;
  localparam logic [DUR_W-1:0] BICOLOR_HALF_RST   = 16'd500;

  // LED1 modes
  localparam logic [1:0] M1_OFF   = 2'd0;
  localparam logic [1:0] M1_ON    = 2'd1;
  localparam logic [1:0] M1_BLINK = 2'd2;

  // LED2 modes
  localparam logic [1:0] M2_OFF   = 2'd0;
  localparam logic [1:0] M2_ON    = 2'd1;
  localparam logic [1:0] M2_SHORT = 2'd2;
  localparam logic [1:0] M2_LONG  = 2'd3;

  // Bicolor modes
  localparam logic [2:0] M3_OFF    = 3'd0;
  localparam logic [2:0] M3_GREEN  = 3'd1;
  localparam logic [2:0] M3_RED    = 3'd2;
  localparam logic [2:0] M3_YELLOW = 3'd3;
  localparam logic [2:0] M3_BLINK  = 3'd4;

  // Bicolor drive colors
  localparam logic [1:0] COLOR_OFF    = 2'd0;
  localparam logic [1:0] COLOR_YELLOW = 2'd3;

  typedef struct packed {
    logic [DUR_W-1:0] heartbeat_half_ms;
    logic [DUR_W-1:0] short_phase_ms;
    logic [DUR_W-1:0] long_phase_ms;
    logic [DUR_W-1:0] bicolor_half_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic step;
    logic restart;
    logic active;
  } blink_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/lmbc_cfg_regs.sv
// Configuration register bank for the blink durations.
`default_nettype none
module lmbc_cfg_regs import lmbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data,
  output cfg_regs_t            regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.heartbeat_half_ms <= HEARTBEAT_HALF_RST;
      regs.short_phase_ms    <= SHORT_PHASE_RST;
      regs.long_phase_ms     <= LONG_PHASE_RST;
      regs.bicolor_half_ms   <= BICOLOR_HALF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEARTBEAT_HALF: regs.heartbeat_half_ms <= cfg_data;
        REG_SHORT_PHASE:    regs.short_phase_ms    <= cfg_data;
        REG_LONG_PHASE:     regs.long_phase_ms     <= cfg_data;
        REG_BICOLOR_HALF:   regs.bicolor_half_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lmbc_blink_timer.sv
// Blink phase timer: phase bit, last toggle time and the due compare.
`default_nettype none
module lmbc_blink_timer import lmbc_pkg::*; #(
  parameter int   TIME_WIDTH = LMBC_TIME_WIDTH,
  parameter logic PHASE_INIT = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  blink_ctrl_t           ctrl,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [DUR_W-1:0]      on_ms,
  input  logic [DUR_W-1:0]      off_ms,
  output logic                  due,
  output logic                  phase_next
);

  logic                  phase;
  logic [TIME_WIDTH-1:0] last;
  logic                  eff_phase;
  logic [TIME_WIDTH-1:0] eff_last;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [TIME_WIDTH-1:0] dur;
  logic [TIME_WIDTH-1:0] last_next;

  always_comb begin
    eff_phase  = ctrl.restart ? 1'b1 : phase;
    eff_last   = ctrl.restart ? now : last;
    elapsed    = now - eff_last;
    dur        = eff_phase ? TIME_WIDTH'(on_ms) : TIME_WIDTH'(off_ms);
    due        = ctrl.active && (elapsed >= dur);
    phase_next = due ? ~eff_phase : eff_phase;
    last_next  = due ? now : eff_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_INIT;
      last  <= '0;
    end else if (ctrl.step) begin
      phase <= phase_next;
      last  <= last_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/led_mode_blink_controller_unit.sv
// LED mode and blink controller: top level with input stage, mode logic and result register.
//
// Usage: each input beat on s_* carries a millisecond timestamp and three button event
// flags; each beat produces exactly one result beat on m_* with the LED drives, the
// current modes and the heartbeat flag. Durations are set through the cfg_* write channel
// (index 0 heartbeat half period, 1 short phase, 2 long phase, 3 bicolor half period);
// other indexes are ignored and cfg_ready is always high. Write only while idle.
// Path: a beat accepted on s_* is presented on m_* through two registers (input stage,
// then result register, with the mode and timer update between them).
// Throughput: one beat per cycle with m_tready high; mode update and three timer compares
// are one registered pass: a new beat enters every cycle while the result register drains.
// Stall: if m_tready is low the result register holds and the input stage fills, after
// which s_tready drops; no beat is dropped or repeated.
// Reset (rst, synchronous): LED1 enters the boot heartbeat lit with its timer at time 0,
// all other modes and drives are off, durations return to 500/200/800/500 ms.
`default_nettype none
module led_mode_blink_controller_unit import lmbc_pkg::*; #(
  parameter int TIME_WIDTH = LMBC_TIME_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // now_time[31:0], key_one_press[32], key_two_press[33], key_three_press[34], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // led_one_lit[0], led_two_lit[1], bicolor_drive[3:2], led_one_mode[5:4],
  // led_two_mode[7:6], bicolor_mode[10:8], heartbeat_active[11], zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DUR_W-1:0]       cfg_data
);

  cfg_regs_t regs;

  lmbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Input stage
  logic             in_valid;
  logic [NOW_W-1:0] in_now;
  logic             in_key1;
  logic             in_key2;
  logic             in_key3;
  logic             advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now  <= s_tdata[NOW_W-1:0];
      in_key1 <= s_tdata[NOW_W];
      in_key2 <= s_tdata[NOW_W+1];
      in_key3 <= s_tdata[NOW_W+2];
    end
  end

  logic [TIME_WIDTH-1:0] now;

  generate
    if (TIME_WIDTH <= NOW_W) begin : g_now_trunc
      assign now = in_now[TIME_WIDTH-1:0];
    end else begin : g_now_ext
      assign now = {{(TIME_WIDTH-NOW_W){1'b0}}, in_now};
    end
  endgenerate

  // Mode state
  logic       boot_heartbeat, boot_next;
  logic [1:0] mode_one, mode_one_next;
  logic [1:0] mode_two, mode_two_next;
  logic [2:0] mode_three, mode_three_next;
  logic       drive_one, drive_one_next;
  logic       drive_two, drive_two_next;
  logic [1:0] drive_three, drive_three_next;

  blink_ctrl_t       ctrl1, ctrl2, ctrl3;
  logic              due1, due2, due3;
  logic              phase1_next, phase2_next, phase3_next;
  logic [DUR_W-1:0]  on2_ms, off2_ms;

  always_comb begin
    boot_next        = boot_heartbeat;
    mode_one_next    = mode_one;
    mode_two_next    = mode_two;
    mode_three_next  = mode_three;
    drive_one_next   = drive_one;
    drive_two_next   = drive_two;
    drive_three_next = drive_three;
    ctrl1            = '{step: advance, restart: 1'b0, active: 1'b0};
    ctrl2            = '{step: advance, restart: 1'b0, active: 1'b0};
    ctrl3            = '{step: advance, restart: 1'b0, active: 1'b0};

    if (in_key1) begin
      if (boot_heartbeat) begin
        boot_next     = 1'b0;
        mode_one_next = M1_OFF;
      end else if (mode_one == M1_BLINK) begin
        mode_one_next = M1_OFF;
      end else begin
        mode_one_next = mode_one + 2'd1;
      end
      case (mode_one_next)
        M1_ON: drive_one_next = 1'b1;
        M1_BLINK: begin
          drive_one_next = 1'b1;
          ctrl1.restart  = 1'b1;
        end
        default: drive_one_next = 1'b0;
      endcase
    end
    ctrl1.active = boot_next || (mode_one_next == M1_BLINK);

    if (in_key2) begin
      mode_two_next = mode_two + 2'd1;
      case (mode_two_next)
        M2_ON: drive_two_next = 1'b1;
        M2_SHORT, M2_LONG: begin
          drive_two_next = 1'b1;
          ctrl2.restart  = 1'b1;
        end
        default: drive_two_next = 1'b0;
      endcase
    end
    ctrl2.active = (mode_two_next == M2_SHORT) || (mode_two_next == M2_LONG);

    if (in_key3) begin
      mode_three_next = (mode_three == M3_BLINK) ? M3_OFF : mode_three + 3'd1;
      if (mode_three_next == M3_BLINK) begin
        drive_three_next = COLOR_YELLOW;
        ctrl3.restart    = 1'b1;
      end else begin
        drive_three_next = mode_three_next[1:0];
      end
    end
    ctrl3.active = (mode_three_next == M3_BLINK);

    if (due1) drive_one_next = phase1_next;
    if (due2) drive_two_next = phase2_next;
    if (due3) drive_three_next = phase3_next ? COLOR_YELLOW : COLOR_OFF;
  end

  assign on2_ms  = (mode_two_next == M2_SHORT) ? regs.short_phase_ms : regs.long_phase_ms;
  assign off2_ms = (mode_two_next == M2_SHORT) ? regs.long_phase_ms : regs.short_phase_ms;

  lmbc_blink_timer #(.TIME_WIDTH(TIME_WIDTH), .PHASE_INIT(1'b1)) u_blink_one (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl1),
    .now        (now),
    .on_ms      (regs.heartbeat_half_ms),
    .off_ms     (regs.heartbeat_half_ms),
    .due        (due1),
    .phase_next (phase1_next)
  );

  lmbc_blink_timer #(.TIME_WIDTH(TIME_WIDTH), .PHASE_INIT(1'b0)) u_blink_two (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl2),
    .now        (now),
    .on_ms      (on2_ms),
    .off_ms     (off2_ms),
    .due        (due2),
    .phase_next (phase2_next)
  );

  lmbc_blink_timer #(.TIME_WIDTH(TIME_WIDTH), .PHASE_INIT(1'b0)) u_blink_three (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl3),
    .now        (now),
    .on_ms      (regs.bicolor_half_ms),
    .off_ms     (regs.bicolor_half_ms),
    .due        (due3),
    .phase_next (phase3_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_heartbeat <= 1'b1;
      mode_one       <= M1_OFF;
      mode_two       <= M2_OFF;
      mode_three     <= M3_OFF;
      drive_one      <= 1'b1;
      drive_two      <= 1'b0;
      drive_three    <= COLOR_OFF;
    end else if (advance) begin
      boot_heartbeat <= boot_next;
      mode_one       <= mode_one_next;
      mode_two       <= mode_two_next;
      mode_three     <= mode_three_next;
      drive_one      <= drive_one_next;
      drive_two      <= drive_two_next;
      drive_three    <= drive_three_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0000, boot_next, mode_three_next, mode_two_next, mode_one_next,
                  drive_three_next, drive_two_next, drive_one_next};
    end
  end

  a_boot_once: assert property (@(posedge clk) disable iff (rst)
    !boot_heartbeat |=> !boot_heartbeat)
    else $error("boot heartbeat re-entered");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed beat did not reach the result register");

  a_boot_mode: assert property (@(posedge clk) disable iff (rst)
    boot_heartbeat |-> (mode_one == M1_OFF))
    else $error("LED1 mode left off during heartbeat");

  a_bicolor_blink: assert property (@(posedge clk) disable iff (rst)
    (mode_three == M3_BLINK) |-> (drive_three == COLOR_OFF || drive_three == COLOR_YELLOW))
    else $error("bicolor blink drives a color other than off or yellow");

endmodule
`default_nettype wire
